// ===== sv/ifc_pkg.sv =====
// Package for the ISO 8473 Fletcher checksum engine.
// Shared types, register indexes and mod-255 helper functions.
// No dependencies.
package ifc_pkg;

   localparam int LEN_W = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VERIFY_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECKSUM_OFFSET = 1'd1;

   localparam logic [7:0] MOD_255 = 8'd255;

   // End-of-message snapshot passed from the accumulator to the finisher
   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [LEN_W-1:0] offset;
      logic [7:0]       sum_a;
      logic [7:0]       sum_b;
      logic [7:0]       rx_first;
      logic [7:0]       rx_second;
      logic             overrun;
      logic             verify;
   } snap_type;

   // (a + b) mod 255 for a in 0..254, b in 0..255
   function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, MOD_255}) begin
         s = s - {1'b0, MOD_255};
      end
      return s[7:0];
   endfunction

   // 16-bit value mod 255 by folding the two octets (256 == 1 mod 255)
   function automatic logic [7:0] fold_mod255(input logic [15:0] x);
      logic [8:0] f;
      logic [8:0] g;
      f = {1'b0, x[15:8]} + {1'b0, x[7:0]};
      g = {1'b0, f[7:0]} + {8'd0, f[8]};
      return (g[7:0] == MOD_255) ? 8'd0 : g[7:0];
   endfunction

endpackage

// ===== sv/ifc_accum.sv =====
// Input register and running-sum accumulator of the Fletcher checksum engine.
// Emits a snapshot of the message state on the last item. Uses ifc_pkg.
module ifc_accum #(
   parameter int MAX_LEN = 65535
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          verify_mode,
   input  logic [ifc_pkg::LEN_W-1:0]     checksum_offset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_last_byte,
   output logic                          snap_valid,
   input  logic                          snap_ready,
   output ifc_pkg::snap_type             snap
);
   import ifc_pkg::*;

   localparam int CountW = $clog2(MAX_LEN + 1);

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_data_ff;
   logic              in_last_ff;
   logic [7:0]        sum_a_ff, sum_a_in;
   logic [7:0]        sum_b_ff, sum_b_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [7:0]        rx_first_ff, rx_first_in;
   logic [7:0]        rx_second_ff, rx_second_in;
   logic              overrun_ff, overrun_in;
   logic              snap_valid_ff, snap_valid_in;
   snap_type          snap_ff, snap_in;

   logic              take;
   logic              saturated;
   logic [LEN_W-1:0]  pos;
   logic              hit_first, hit_second;
   logic [7:0]        octet;
   logic [7:0]        step_a, step_b;
   logic [CountW-1:0] step_count;
   logic [7:0]        step_rx_first, step_rx_second;
   logic              step_overrun;

   // Stage item is consumed unless it is a last item blocked by a full snapshot
   assign take      = in_valid_ff && (!in_last_ff || !snap_valid_ff || snap_ready);
   assign req_ready = !in_valid_ff || take;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Position checks against the checksum octets
   assign saturated  = (count_ff == CountW'(MAX_LEN));
   assign pos        = LEN_W'(count_ff);
   assign hit_first  = (pos == checksum_offset);
   assign hit_second = ({1'b0, pos} == ({1'b0, checksum_offset} + 17'd1));
   assign octet      = ((hit_first || hit_second) && !verify_mode) ? 8'd0 : in_data_ff;

   // One octet of accumulation; dropped once the count is saturated
   always_comb begin
      step_a         = sum_a_ff;
      step_b         = sum_b_ff;
      step_count     = count_ff;
      step_rx_first  = rx_first_ff;
      step_rx_second = rx_second_ff;
      step_overrun   = overrun_ff;
      if (saturated) begin
         step_overrun = 1'b1;
      end else begin
         step_a     = add_mod255(sum_a_ff, octet);
         step_b     = add_mod255(sum_b_ff, step_a);
         step_count = count_ff + CountW'(1);
         if (hit_first) begin
            step_rx_first = in_data_ff;
         end else if (hit_second) begin
            step_rx_second = in_data_ff;
         end
      end
   end

   // Message state: advanced on each taken item, cleared after the last item
   always_comb begin
      sum_a_in     = sum_a_ff;
      sum_b_in     = sum_b_ff;
      count_in     = count_ff;
      rx_first_in  = rx_first_ff;
      rx_second_in = rx_second_ff;
      overrun_in   = overrun_ff;
      if (take && in_last_ff) begin
         sum_a_in     = 8'd0;
         sum_b_in     = 8'd0;
         count_in     = '0;
         rx_first_in  = 8'd0;
         rx_second_in = 8'd0;
         overrun_in   = 1'b0;
      end else if (take) begin
         sum_a_in     = step_a;
         sum_b_in     = step_b;
         count_in     = step_count;
         rx_first_in  = step_rx_first;
         rx_second_in = step_rx_second;
         overrun_in   = step_overrun;
      end
   end

   // Snapshot register toward the finisher
   always_comb begin
      snap_in = snap_ff;
      if (take && in_last_ff) begin
         snap_valid_in     = 1'b1;
         snap_in.len       = LEN_W'(step_count);
         snap_in.offset    = checksum_offset;
         snap_in.sum_a     = step_a;
         snap_in.sum_b     = step_b;
         snap_in.rx_first  = step_rx_first;
         snap_in.rx_second = step_rx_second;
         snap_in.overrun   = step_overrun;
         snap_in.verify    = verify_mode;
      end else if (snap_ready) begin
         snap_valid_in = 1'b0;
      end else begin
         snap_valid_in = snap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         sum_a_ff      <= 8'd0;
         sum_b_ff      <= 8'd0;
         count_ff      <= '0;
         rx_first_ff   <= 8'd0;
         rx_second_ff  <= 8'd0;
         overrun_ff    <= 1'b0;
         snap_valid_ff <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         sum_a_ff      <= sum_a_in;
         sum_b_ff      <= sum_b_in;
         count_ff      <= count_in;
         rx_first_ff   <= rx_first_in;
         rx_second_ff  <= rx_second_in;
         overrun_ff    <= overrun_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      snap_ff <= snap_in;
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

// ===== sv/ifc_finish.sv =====
// Checksum finisher: turns a message snapshot into the result item.
// Two stages (weight multiply, then mod-255 reduction) ending in the output register.
// Uses ifc_pkg.
module ifc_finish (
   input  logic              clock,
   input  logic              reset,
   input  logic              snap_valid,
   output logic              snap_ready,
   input  ifc_pkg::snap_type snap,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_check_first,
   output logic [7:0]        rsp_check_second,
   output logic              rsp_checksum_ok,
   output logic              rsp_offset_error,
   output logic              rsp_length_error
);
   import ifc_pkg::*;

   typedef struct packed {
      logic [15:0] prod;
      logic [7:0]  sum_a;
      logic [7:0]  sum_b;
      logic        rx_zero;
      logic        verify;
      logic        off_err;
      logic        len_err;
   } mid_type;

   typedef struct packed {
      logic [7:0] first;
      logic [7:0] second;
      logic       ok;
      logic       off_err;
      logic       len_err;
   } out_type;

   logic        mid_valid_ff, mid_valid_in;
   mid_type     mid_ff, mid_in;
   logic        out_valid_ff, out_valid_in;
   out_type     out_ff, out_in;
   logic        out_ready, mid_ready;

   logic [LEN_W-1:0] span;
   logic [7:0]       weight;
   logic [7:0]       prod_mod;
   logic [8:0]       diff;
   logic [7:0]       first_raw, first_val;
   logic [9:0]       second_raw;
   logic [7:0]       second_val;
   logic             any_err;

   assign out_ready  = !out_valid_ff || rsp_ready;
   assign mid_ready  = !mid_valid_ff || out_ready;
   assign snap_ready = mid_ready;

   // Stage 1: weight (L-k-1) mod 255, times sum_a
   always_comb begin
      span          = snap.len - snap.offset - LEN_W'(1);
      weight        = fold_mod255(span);
      mid_in        = mid_ff;
      mid_valid_in  = mid_valid_ff;
      if (mid_ready) begin
         mid_valid_in   = snap_valid;
         mid_in.prod    = {8'd0, weight} * {8'd0, snap.sum_a};
         mid_in.sum_a   = snap.sum_a;
         mid_in.sum_b   = snap.sum_b;
         mid_in.rx_zero = (snap.rx_first == 8'd0) && (snap.rx_second == 8'd0);
         mid_in.verify  = snap.verify;
         mid_in.off_err = ({1'b0, snap.offset} + 17'd1) >= {1'b0, snap.len};
         mid_in.len_err = snap.overrun;
      end
   end

   // Stage 2: reduce, form both octets, mask by mode and errors
   always_comb begin
      prod_mod  = fold_mod255(mid_ff.prod);
      diff      = {1'b0, prod_mod} - {1'b0, mid_ff.sum_b};
      first_raw = diff[8] ? (diff[7:0] + MOD_255) : diff[7:0];
      first_val = (first_raw == 8'd0) ? MOD_255 : first_raw;
      second_raw = 10'd510 - {2'b00, mid_ff.sum_a} - {2'b00, first_val};
      second_val = (second_raw > 10'd255) ? 8'(second_raw - 10'd255) : second_raw[7:0];
      any_err   = mid_ff.off_err || mid_ff.len_err;

      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (out_ready) begin
         out_valid_in   = mid_valid_ff;
         out_in.first   = (!any_err && !mid_ff.verify) ? first_val : 8'd0;
         out_in.second  = (!any_err && !mid_ff.verify) ? second_val : 8'd0;
         out_in.ok      = !any_err && mid_ff.verify &&
                          (mid_ff.rx_zero || (mid_ff.sum_a == 8'd0 && mid_ff.sum_b == 8'd0));
         out_in.off_err = mid_ff.off_err;
         out_in.len_err = mid_ff.len_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mid_ff <= mid_in;
      out_ff <= out_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_check_first  = out_ff.first;
   assign rsp_check_second = out_ff.second;
   assign rsp_checksum_ok  = out_ff.ok;
   assign rsp_offset_error = out_ff.off_err;
   assign rsp_length_error = out_ff.len_err;

endmodule

// ===== sv/iso_fletcher_checksum_engine.sv =====
// Top level of the ISO 8473 Fletcher checksum engine (mod 255).
// Holds the configuration registers; uses ifc_pkg, ifc_accum and ifc_finish.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | data_byte, last_byte
//   rsp     | out       | rsp_valid / rsp_ready | check_first, check_second, flags
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// One byte is accepted per cycle unless a last byte waits on a full snapshot; the running
// sums update once per byte. A result reaches rsp through the snapshot, multiply stage
// and output registers, which follow the input register.
// Reset clears configuration, sums, count and all valid flags.
// A stalled result blocks a later last byte and the bytes behind it; earlier bytes keep flowing.
module iso_fletcher_checksum_engine #(
   parameter int MAX_LEN = 65535
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_last_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_check_first,
   output logic [7:0]                      rsp_check_second,
   output logic                            rsp_checksum_ok,
   output logic                            rsp_offset_error,
   output logic                            rsp_length_error,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ifc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ifc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ifc_pkg::*;

   logic             verify_mode_ff, verify_mode_in;
   logic [LEN_W-1:0] offset_ff, offset_in;
   logic             snap_valid, snap_ready;
   snap_type         snap;

   // Configuration registers, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      verify_mode_in = verify_mode_ff;
      offset_in      = offset_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_VERIFY_MODE:     verify_mode_in = csr_wdata[0];
            CSR_CHECKSUM_OFFSET: offset_in      = csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         verify_mode_ff <= 1'b0;
         offset_ff      <= '0;
      end else begin
         verify_mode_ff <= verify_mode_in;
         offset_ff      <= offset_in;
      end
   end

   ifc_accum #(
      .MAX_LEN(MAX_LEN)
   ) u_accum (
      .clock           (clock),
      .reset           (reset),
      .verify_mode     (verify_mode_ff),
      .checksum_offset (offset_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .snap_valid      (snap_valid),
      .snap_ready      (snap_ready),
      .snap            (snap)
   );

   ifc_finish u_finish (
      .clock            (clock),
      .reset            (reset),
      .snap_valid       (snap_valid),
      .snap_ready       (snap_ready),
      .snap             (snap),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_check_first  (rsp_check_first),
      .rsp_check_second (rsp_check_second),
      .rsp_checksum_ok  (rsp_checksum_ok),
      .rsp_offset_error (rsp_offset_error),
      .rsp_length_error (rsp_length_error)
   );

   // An error suppresses every result field
   a_err_masks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_offset_error || rsp_length_error) |->
         rsp_check_first == 8'd0 && rsp_check_second == 8'd0 && !rsp_checksum_ok)
      else $error("result fields set alongside an error flag");

   // Computed octets come as a pair, never with a verify verdict
   a_octet_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_check_first != 8'd0 |->
         rsp_check_second != 8'd0 && !rsp_checksum_ok)
      else $error("check octets inconsistent");

   // A snapshot waits while the finisher is full
   a_snap_hold: assert property (@(posedge clock) disable iff (reset)
      snap_valid && !snap_ready |=> snap_valid && $stable(snap))
      else $error("snapshot lost under stall");

endmodule

// ===== tb/tb_iso_fletcher_checksum_engine.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for iso_fletcher_checksum_engine (mod-255 Fletcher).
// Drives messages and register writes and checks each result against a local model.
// Depends on ifc_pkg and the engine RTL.
module tb_iso_fletcher_checksum_engine;
   import ifc_pkg::*;

   localparam int MSG_MAX = 65535;
   localparam int RANDOM_ITEMS = 2000;
   localparam int PIPE_SLACK = 10;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } octet_item_type;

   typedef struct packed {
      logic [7:0] first;
      logic [7:0] second;
      logic       ok;
      logic       off_err;
      logic       len_err;
   } checksum_type;

   typedef enum {MSG_PLAIN, MSG_SEALED, MSG_ZERO_CHECK, MSG_BROKEN} msg_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_data_byte = 8'd0;
   logic req_last_byte = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_check_first;
   logic [7:0] rsp_check_second;
   logic rsp_checksum_ok;
   logic rsp_offset_error;
   logic rsp_length_error;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_VERIFY_MODE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // configuration shadow and running message state
   logic        cfg_verify = 1'b0;
   int unsigned cfg_offset = 0;
   int unsigned acc_a = 0;
   int unsigned acc_b = 0;
   int unsigned msg_count = 0;
   logic [7:0]  rx_first = 8'd0;
   logic [7:0]  rx_second = 8'd0;
   logic        overrun = 1'b0;

   octet_item_type octet_queue[$];
   checksum_type   checksum_expect[$];
   checksum_type   rsp_expected;
   octet_item_type next_item;

   int  mismatch_count = 0;
   int  items_queued = 0;
   bit  idle_on = 1'b1;
   bit  req_taken = 1'b0;
   bit  rsp_taken = 1'b0;
   bit  req_hold;
   int  req_gap = 0;
   int  rsp_gap = 0;

   iso_fletcher_checksum_engine #(.MAX_LEN(MSG_MAX)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_check_first  (rsp_check_first),
      .rsp_check_second (rsp_check_second),
      .rsp_checksum_ok  (rsp_checksum_ok),
      .rsp_offset_error (rsp_offset_error),
      .rsp_length_error (rsp_length_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   // checksum octets from the final sums; shared by prediction and message sealing
   function automatic void fletcher_octets(input int unsigned len, input int unsigned k,
                                           input int unsigned sa, input int unsigned sb,
                                           output logic [7:0] c1, output logic [7:0] c2);
      int unsigned f;
      int unsigned s;
      f = ((((len - k - 1) % 255) * sa) + 255 - sb) % 255;
      if (f == 0) f = 255;
      s = 510 - sa - f;
      if (s > 255) s = s - 255;
      c1 = f[7:0];
      c2 = s[7:0];
   endfunction

   // advance the running sums by one accepted item; queue a result on the last one
   task automatic fletcher_step(input logic [7:0] octet, input logic last);
      int unsigned v;
      checksum_type r;
      if (msg_count >= MSG_MAX) begin
         overrun = 1'b1;
      end else begin
         v = 32'(octet);
         if (msg_count == cfg_offset) begin
            rx_first = octet;
            if (!cfg_verify) v = 0;
         end else if (msg_count == cfg_offset + 1) begin
            rx_second = octet;
            if (!cfg_verify) v = 0;
         end
         acc_a = (acc_a + v) % 255;
         acc_b = (acc_b + acc_a) % 255;
         msg_count = msg_count + 1;
      end
      if (last) begin
         r = '0;
         r.off_err = (cfg_offset + 1 >= msg_count);
         r.len_err = overrun;
         if (!r.off_err && !r.len_err) begin
            if (cfg_verify) begin
               r.ok = ((rx_first == 8'd0) && (rx_second == 8'd0)) ||
                      ((acc_a == 0) && (acc_b == 0));
            end else begin
               fletcher_octets(msg_count, cfg_offset, acc_a, acc_b, r.first, r.second);
            end
         end
         checksum_expect.push_back(r);
         acc_a = 0;
         acc_b = 0;
         msg_count = 0;
         rx_first = 8'd0;
         rx_second = 8'd0;
         overrun = 1'b0;
      end
   endtask

   task automatic check_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            fletcher_step(req_data_byte, req_last_byte);
            req_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            rsp_taken = 1'b1;
            if (checksum_expect.size() == 0) begin
               $display("%0t: unexpected result, expected none, got first %0d second %0d",
                        $time, rsp_check_first, rsp_check_second);
               mismatch_count++;
            end else begin
               rsp_expected = checksum_expect.pop_front();
               check_field("check_first", 32'(rsp_expected.first), 32'(rsp_check_first));
               check_field("check_second", 32'(rsp_expected.second), 32'(rsp_check_second));
               check_field("checksum_ok", 32'(rsp_expected.ok), 32'(rsp_checksum_ok));
               check_field("offset_error", 32'(rsp_expected.off_err),
                           32'(rsp_offset_error));
               check_field("length_error", 32'(rsp_expected.len_err),
                           32'(rsp_length_error));
            end
         end
      end
   end

   // input driver: one item at a time from the queue, random gap after each while idle_on is set
   always @(negedge clock) begin
      if (!reset) begin
         req_hold = req_valid && !req_taken;
         if (req_taken) begin
            req_taken = 1'b0;
            req_gap = idle_on ? $urandom_range(0, 6) : 0;
         end
         if (!req_hold) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (octet_queue.size() > 0) begin
               next_item = octet_queue.pop_front();
               req_data_byte <= next_item.data;
               req_last_byte <= next_item.last;
               req_hold = 1'b1;
            end
         end
         req_valid <= req_hold;
      end
   end

   // result side: random stall before each item while idle_on is set
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rsp_gap = idle_on ? $urandom_range(0, 6) : 0;
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic logic [7:0] rand_octet();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // wait until every item is sent and every result is back, then let the pipe empty
   task automatic wait_drain();
      while (octet_queue.size() != 0 || req_valid || checksum_expect.size() != 0)
         @(posedge clock);
      repeat (PIPE_SLACK) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_VERIFY_MODE) cfg_verify = val[0];
      else cfg_offset = 32'(val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic verify, input int unsigned offset);
      logic [CSR_DATA_W-1:0] mode_word;
      wait_drain();
      mode_word = CSR_DATA_W'($urandom_range(0, 65535));
      mode_word[0] = verify;
      write_csr(CSR_VERIFY_MODE, mode_word);
      write_csr(CSR_CHECKSUM_OFFSET, offset[CSR_DATA_W-1:0]);
   endtask

   task automatic push_octet(input logic [7:0] data, input logic last);
      octet_item_type it;
      it.data = data;
      it.last = last;
      octet_queue.push_back(it);
      items_queued++;
   endtask

   // queue one message; sealed messages carry valid checksum octets at the offset
   task automatic build_message(input int unsigned len, input msg_kind_type kind);
      logic [7:0] msg[];
      int unsigned sa;
      int unsigned sb;
      int unsigned v;
      int unsigned pick;
      logic [7:0] c1;
      logic [7:0] c2;
      msg = new[len];
      foreach (msg[i]) msg[i] = rand_octet();
      if (kind != MSG_PLAIN && cfg_offset + 1 < len) begin
         if (kind == MSG_ZERO_CHECK) begin
            msg[cfg_offset] = 8'd0;
            msg[cfg_offset + 1] = 8'd0;
         end else begin
            sa = 0;
            sb = 0;
            foreach (msg[i]) begin
               v = (i == cfg_offset || i == cfg_offset + 1) ? 0 : 32'(msg[i]);
               sa = (sa + v) % 255;
               sb = (sb + sa) % 255;
            end
            fletcher_octets(len, cfg_offset, sa, sb, c1, c2);
            msg[cfg_offset] = c1;
            msg[cfg_offset + 1] = c2;
            if (kind == MSG_BROKEN) begin
               pick = $urandom_range(0, len - 1);
               msg[pick] = msg[pick] ^ (8'd1 << $urandom_range(0, 7));
            end
         end
      end
      foreach (msg[i]) push_octet(msg[i], i == len - 1);
   endtask

   initial begin
      int unsigned k;
      int unsigned len;
      int unsigned pick;
      int unsigned random_start;
      logic mode;
      msg_kind_type kind;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: compute mode at reset settings (offset 0)
      push_octet(8'hFF, 1'b1);
      push_octet(8'h00, 1'b0);
      push_octet(8'h00, 1'b1);
      repeat (3) push_octet(8'hFF, 1'b0);
      push_octet(8'hFF, 1'b1);
      push_octet(8'h01, 1'b0);
      push_octet(8'h80, 1'b0);
      push_octet(8'h7F, 1'b0);
      push_octet(8'hFE, 1'b0);
      push_octet(8'hFF, 1'b1);

      // directed: verify mode, sealed, zero checksum, broken, offset outside message
      set_config(1'b1, 1);
      build_message(5, MSG_SEALED);
      build_message(4, MSG_ZERO_CHECK);
      build_message(4, MSG_BROKEN);
      push_octet(8'hAA, 1'b0);
      push_octet(8'h55, 1'b1);

      // random phases
      random_start = items_queued;
      while (items_queued - random_start < RANDOM_ITEMS) begin
         mode = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0: k = 0;
            1: k = $urandom_range(16, 200);
            2: k = 65533;
            default: k = $urandom_range(0, 15);
         endcase
         idle_on = ($urandom_range(0, 3) != 0);
         set_config(mode, k);
         repeat ($urandom_range(4, 12)) begin
            if (k > 1000 || $urandom_range(0, 7) == 0) begin
               len = $urandom_range(1, (k + 1 > 40) ? 40 : k + 1);
            end else begin
               len = k + $urandom_range(2, 40);
            end
            kind = MSG_PLAIN;
            if (mode) begin
               pick = $urandom_range(0, 9);
               if (pick < 7) kind = MSG_SEALED;
               else if (pick == 7) kind = MSG_ZERO_CHECK;
               else if (pick == 8) kind = MSG_BROKEN;
            end
            build_message(len, kind);
         end
      end

      wait_drain();
      if (mismatch_count == 0 && checksum_expect.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
